>>> rtl/rotated_framebuffer_window_access_assert.svh
// Assertion macros used by the frame store RTL.
`ifndef ROTATED_FRAMEBUFFER_WINDOW_ACCESS_ASSERT_SVH
`define ROTATED_FRAMEBUFFER_WINDOW_ACCESS_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define RFB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Frame store assertion failed in the same cycle.");

// Checks that the consequent holds in the cycle after the antecedent.
`define RFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Frame store assertion failed one cycle later.");

`endif

>>> rtl/rfb_win_pkg.sv
// Package with panel geometry, command codes and shared types of the frame store.
package rfb_win_pkg;

    localparam int PANEL_WIDTH  = 80;
    localparam int PANEL_HEIGHT = 160;
    localparam int STORE_SIZE   = PANEL_WIDTH * PANEL_HEIGHT;
    localparam int ADDR_W       = $clog2(STORE_SIZE);

    localparam logic [7:0] PANEL_W8   = 8'(PANEL_WIDTH);
    localparam logic [7:0] PANEL_H8   = 8'(PANEL_HEIGHT);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_SIZE - 1);

    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    typedef enum logic [1:0] {
        CMD_START_WR = 2'd0,
        CMD_WR_PIXEL = 2'd1,
        CMD_START_RD = 2'd2,
        CMD_RD_PIXEL = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } t_state;

    typedef struct packed {
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] cols_left;
        logic [7:0] rows_left;
        logic [7:0] win_x;
        logic [7:0] win_y;
        logic [7:0] win_cols;
        logic [7:0] win_rows;
    } t_cursor;

endpackage

>>> rtl/rotated_framebuffer_window_access.sv
// Rotated frame store with windowed write and read cursors.
//
// The block holds an 80 by 160 store of RGB565 words in one single-port synchronous
// memory. Each request (start window, write pixel or read pixel) is accepted while
// o_in_stall is low, so a request can follow in every cycle that is not stalled. A
// pixel request maps its cursor to a store address in the accept cycle, registers it
// in stage one and reaches the memory port from there; a read result is registered
// in the output stage. Because every access uses the same memory port in request
// order, a read sees all earlier writes. After reset the block clears all 12800 words
// of the store, one word per cycle, and accepts no request meanwhile; rotation writes
// are taken at any time. A stalled read result holds the pipeline.
`include "rotated_framebuffer_window_access_assert.svh"

module rotated_framebuffer_window_access (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_window_x,
    input  logic [7:0]  i_window_y,
    input  logic [7:0]  i_window_cols,
    input  logic [7:0]  i_window_rows,
    input  logic [15:0] i_pixel_color,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_read_color
);

    localparam int AW = rfb_win_pkg::ADDR_W;

    logic [15:0] r_mem [rfb_win_pkg::STORE_SIZE];

    rfb_win_pkg::t_state  r_state;
    logic [AW-1:0]        r_clr_addr;
    logic [1:0]           r_rotation;
    rfb_win_pkg::t_cursor r_wr_cur, n_wr_cur;
    rfb_win_pkg::t_cursor r_rd_cur, n_rd_cur;

    logic          r_s1_valid;
    logic          r_s1_wr;
    logic          r_s1_rd;
    logic          r_s1_in;
    logic [AW-1:0] r_s1_addr, n_s1_addr;
    logic [15:0]   r_s1_color;

    logic          r_o_valid;
    logic          r_o_zero;
    logic [15:0]   r_rdata;

    logic                 pipe_en;
    logic                 accept;
    rfb_win_pkg::t_cmd    cmd;
    rfb_win_pkg::t_cursor sel_cur;
    logic [7:0]           log_w, log_h;
    logic [7:0]           row, col;
    logic                 n_s1_in;
    logic [15:0]          lin_addr;

    function automatic rfb_win_pkg::t_cursor step_cursor(input rfb_win_pkg::t_cursor c);
        rfb_win_pkg::t_cursor s;
        s = c;
        s.x = c.x + 8'd1;
        s.cols_left = c.cols_left - 8'd1;
        if (s.cols_left == 8'd0) begin
            s.x = c.win_x;
            s.cols_left = c.win_cols;
            s.y = c.y + 8'd1;
            s.rows_left = c.rows_left - 8'd1;
            if (s.rows_left == 8'd0) begin
                s.y = c.win_y;
                s.rows_left = c.win_rows;
            end
        end
        return s;
    endfunction

    function automatic rfb_win_pkg::t_cursor load_cursor(
        input logic [7:0] x, input logic [7:0] y,
        input logic [7:0] cols, input logic [7:0] rows
    );
        rfb_win_pkg::t_cursor s;
        s.x = x;
        s.y = y;
        s.cols_left = cols;
        s.rows_left = rows;
        s.win_x = x;
        s.win_y = y;
        s.win_cols = cols;
        s.win_rows = rows;
        return s;
    endfunction

    assign pipe_en    = !(r_o_valid && i_out_stall);
    assign o_in_stall = (r_state != rfb_win_pkg::ST_RUN) || !pipe_en;
    assign accept     = i_in_valid && !o_in_stall;
    assign cmd        = rfb_win_pkg::t_cmd'(i_command);

    // Address mapping for the cursor that the current request uses.
    always_comb begin
        sel_cur = (cmd == rfb_win_pkg::CMD_WR_PIXEL) ? r_wr_cur : r_rd_cur;
        log_w = r_rotation[0] ? rfb_win_pkg::PANEL_H8 : rfb_win_pkg::PANEL_W8;
        log_h = r_rotation[0] ? rfb_win_pkg::PANEL_W8 : rfb_win_pkg::PANEL_H8;
        n_s1_in = (sel_cur.x < log_w) && (sel_cur.y < log_h);
        unique case (r_rotation)
            rfb_win_pkg::ROT_0: begin
                row = sel_cur.y;
                col = sel_cur.x;
            end
            rfb_win_pkg::ROT_90: begin
                row = rfb_win_pkg::PANEL_H8 - 8'd1 - sel_cur.x;
                col = sel_cur.y;
            end
            rfb_win_pkg::ROT_180: begin
                row = rfb_win_pkg::PANEL_H8 - 8'd1 - sel_cur.y;
                col = rfb_win_pkg::PANEL_W8 - 8'd1 - sel_cur.x;
            end
            default: begin
                row = sel_cur.x;
                col = rfb_win_pkg::PANEL_W8 - 8'd1 - sel_cur.y;
            end
        endcase
        lin_addr  = 16'(row) * 16'(rfb_win_pkg::PANEL_W8) + 16'(col);
        n_s1_addr = lin_addr[AW-1:0];
    end

    always_comb begin
        n_wr_cur = r_wr_cur;
        n_rd_cur = r_rd_cur;
        if (accept) begin
            unique case (cmd)
                rfb_win_pkg::CMD_START_WR: n_wr_cur = load_cursor(i_window_x, i_window_y,
                                                                  i_window_cols, i_window_rows);
                rfb_win_pkg::CMD_WR_PIXEL: n_wr_cur = step_cursor(r_wr_cur);
                rfb_win_pkg::CMD_START_RD: n_rd_cur = load_cursor(i_window_x, i_window_y,
                                                                  i_window_cols, i_window_rows);
                default:                   n_rd_cur = step_cursor(r_rd_cur);
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= rfb_win_pkg::ST_CLEAR;
            r_clr_addr <= '0;
            r_rotation <= rfb_win_pkg::ROT_0;
            r_wr_cur   <= '0;
            r_rd_cur   <= '0;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_rotation <= i_cfg_wr_data;
            end
            unique case (r_state)
                rfb_win_pkg::ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == rfb_win_pkg::LAST_ADDR) begin
                        r_state <= rfb_win_pkg::ST_RUN;
                    end
                end
                default: begin
                    r_state <= rfb_win_pkg::ST_RUN;
                end
            endcase
            r_wr_cur <= n_wr_cur;
            r_rd_cur <= n_rd_cur;
            if (pipe_en) begin
                r_s1_valid <= accept && ((cmd == rfb_win_pkg::CMD_WR_PIXEL) ||
                                         (cmd == rfb_win_pkg::CMD_RD_PIXEL));
                r_o_valid  <= r_s1_valid && r_s1_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_s1_wr    <= (cmd == rfb_win_pkg::CMD_WR_PIXEL);
            r_s1_rd    <= (cmd == rfb_win_pkg::CMD_RD_PIXEL);
            r_s1_in    <= n_s1_in;
            r_s1_addr  <= n_s1_addr;
            r_s1_color <= i_pixel_color;
            r_o_zero   <= !r_s1_in;
        end
    end

    // Single memory port: clearing sweep, or the pixel access of the request in stage one.
    always_ff @(posedge i_clk) begin
        if (r_state == rfb_win_pkg::ST_CLEAR) begin
            r_mem[r_clr_addr] <= 16'd0;
        end else if (pipe_en && r_s1_valid && r_s1_in) begin
            if (r_s1_wr) begin
                r_mem[r_s1_addr] <= r_s1_color;
            end else begin
                r_rdata <= r_mem[r_s1_addr];
            end
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_read_color = r_o_zero ? 16'd0 : r_rdata;

    `RFB_ASSERT_SAME(a_no_accept_in_clear, i_clk, i_rst_n,
        r_state == rfb_win_pkg::ST_CLEAR, o_in_stall && !r_s1_valid)
    `RFB_ASSERT_SAME(a_clear_addr_range, i_clk, i_rst_n,
        r_state == rfb_win_pkg::ST_CLEAR, r_clr_addr <= rfb_win_pkg::LAST_ADDR)
    `RFB_ASSERT_NEXT(a_read_gives_result, i_clk, i_rst_n,
        pipe_en && r_s1_valid && r_s1_rd, r_o_valid)
    `RFB_ASSERT_NEXT(a_write_gives_none, i_clk, i_rst_n,
        pipe_en && r_s1_valid && r_s1_wr, !r_o_valid)

endmodule
